// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// shared constants, codes and types of the first-fit frame allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // frame table geometry
  localparam int NUM_FRAMES = 64;
  localparam int ID_BITS    = 16;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);

  // field widths
  localparam int CFG_CNT_BITS  = 7;
  localparam int BYTES_BITS    = 16;
  localparam int STATUS_BITS   = 2;
  localparam int START_BITS    = 6;
  localparam int RESIDENT_BITS = 7;
  localparam int FRAG_BITS     = 22;
  localparam int PROD_BITS     = CFG_CNT_BITS + BYTES_BITS;

  // stream word layout
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_USED_BITS = STATUS_BITS + START_BITS + RESIDENT_BITS + FRAG_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES_IN_USE      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_BYTES        = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES_PER_PROCESS = 2'd2;

  localparam logic [CFG_CNT_BITS-1:0] RST_FRAMES_IN_USE      = 7'd64;
  localparam logic [BYTES_BITS-1:0]   RST_FRAME_BYTES        = 16'd16;
  localparam logic [CFG_CNT_BITS-1:0] RST_FRAMES_PER_PROCESS = 7'd4;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE     = 2'd0,
    ST_RESIDENT = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_NO_RUN   = 2'd3
  } status_t;

  localparam logic [FRAG_BITS-1:0] FRAG_MAX = {FRAG_BITS{1'b1}};

endpackage

`default_nettype wire

// ===== hw/rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_frame_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_frame_allocator_core
// first-fit contiguous frame allocator with owner table in ram
// ----------------------------------------------------------------------------
// sequence: an owner ram scan (one frame per cycle), the run write-back on a
//   successful allocate, a fragmentation pass over busy bits, a multiply and
//   the result load, which waits while the output register is still full
// requests: one at a time, the next one taken the cycle after the result word
//   is loaded
// reset: synchronous, all frames free, no residents, config back to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_frame_allocator_core
  import ffa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] process_id
  input  wire logic [0:0]               s_tuser,   // [0] cmd
  // result stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic      [OUT_DATA_BITS-1:0] m_tdata,   // [1:0] status, [7:2] start_frame,
                                                   // [14:8] resident_count,
                                                   // [36:15] fragment_bytes, [39:37] zero
  // config write channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FRAG,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state;

  // config registers
  logic [CFG_CNT_BITS-1:0] frames_in_use;
  logic [BYTES_BITS-1:0]   frame_bytes;
  logic [CFG_CNT_BITS-1:0] frames_per_process;

  // table state
  logic [NUM_FRAMES-1:0]    busy;
  logic [RESIDENT_BITS-1:0] resident_total;

  // current request
  logic               req_cmd;
  logic [ID_BITS-1:0] req_id;

  // scan bookkeeping
  logic [CNT_BITS-1:0]   idx;
  logic                  owner_hit;
  logic [CNT_BITS-1:0]   fit_run;
  logic [FRAME_BITS-1:0] fit_start;
  logic [FRAME_BITS-1:0] run_start;
  logic                  fit_found;

  // write-back bookkeeping
  logic [FRAME_BITS-1:0]   wr_idx;
  logic [CFG_CNT_BITS-1:0] wr_cnt;

  // fragmentation bookkeeping
  logic [CNT_BITS-1:0]  free_n;
  logic [CNT_BITS-1:0]  best_run;
  logic [CNT_BITS-1:0]  cur_run;
  logic [PROD_BITS-1:0] frag_prod;

  // result fields
  status_t               res_status;
  logic [START_BITS-1:0] res_start;

  // ram ports
  logic                  ram_we;
  logic [ID_BITS-1:0]    ram_rdata;
  logic [FRAME_BITS-1:0] ram_raddr;

  // derived values
  logic [CFG_CNT_BITS-1:0] lim;
  logic [CNT_BITS-1:0]     prev_idx;
  logic                    owner_cmp;
  logic                    hit_all;
  logic                    idx_busy;
  logic                    in_region;
  logic                    fit_now;
  logic [CNT_BITS-1:0]     fit_run_inc;
  logic [CNT_BITS-1:0]     cur_run_inc;
  logic [CNT_BITS-1:0]     frag_diff;
  logic [FRAG_BITS-1:0]    frag_sat;

  // managed frame count, clipped to the table size
  assign lim = (frames_in_use > CFG_CNT_BITS'(NUM_FRAMES)) ?
               CFG_CNT_BITS'(NUM_FRAMES) : frames_in_use;

  // owner compare uses the registered read of the previous address
  assign prev_idx  = idx - CNT_BITS'(1);
  assign owner_cmp = (idx != '0) && busy[prev_idx[FRAME_BITS-1:0]] && (ram_rdata == req_id);
  assign hit_all   = owner_hit | owner_cmp;

  // per-frame run tracking; busy and region flags shared by the fit and fragmentation passes
  assign idx_busy    = busy[idx[FRAME_BITS-1:0]];
  assign in_region   = (idx < CNT_BITS'(NUM_FRAMES)) && (idx < CNT_BITS'(lim));
  assign fit_run_inc = fit_run + CNT_BITS'(1);
  assign fit_now     = in_region && !idx_busy && !fit_found &&
                       (fit_run_inc == CNT_BITS'(frames_per_process));
  assign cur_run_inc = cur_run + CNT_BITS'(1);

  assign frag_diff = free_n - best_run;
  assign frag_sat  = (frag_prod > PROD_BITS'(FRAG_MAX)) ? FRAG_MAX : frag_prod[FRAG_BITS-1:0];

  assign ram_raddr = idx[FRAME_BITS-1:0];
  assign ram_we    = (state == S_WRITE);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // owner table
  ffa_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (NUM_FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (req_id),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use      <= RST_FRAMES_IN_USE;
      frame_bytes        <= RST_FRAME_BYTES;
      frames_per_process <= RST_FRAMES_PER_PROCESS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAMES_IN_USE:      frames_in_use      <= cfg_data[CFG_CNT_BITS-1:0];
        REG_FRAME_BYTES:        frame_bytes        <= cfg_data[BYTES_BITS-1:0];
        REG_FRAMES_PER_PROCESS: frames_per_process <= cfg_data[CFG_CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // request sequencer, table update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      busy           <= '0;
      resident_total <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        // take a request and clear the scan state
        S_IDLE: begin
          if (s_tvalid) begin
            req_cmd    <= s_tuser[0];
            req_id     <= s_tdata[ID_BITS-1:0];
            idx        <= '0;
            owner_hit  <= 1'b0;
            fit_run    <= '0;
            fit_found  <= 1'b0;
            fit_start  <= '0;
            run_start  <= '0;
            res_status <= ST_DONE;
            res_start  <= '0;
            state      <= S_SCAN;
          end
        end

        // one frame per cycle: owner match, release on free, first fit
        S_SCAN: begin
          if (owner_cmp) begin
            owner_hit <= 1'b1;
            if (req_cmd == CMD_FREE) begin
              busy[prev_idx[FRAME_BITS-1:0]] <= 1'b0;
            end
          end
          if (in_region) begin
            if (idx_busy) begin
              fit_run <= '0;
            end else begin
              fit_run <= fit_run_inc;
              if (fit_run == '0) begin
                run_start <= idx[FRAME_BITS-1:0];
              end
            end
          end
          if (fit_now) begin
            fit_found <= 1'b1;
            fit_start <= (fit_run == '0) ? idx[FRAME_BITS-1:0] : run_start;
          end
          if (idx == CNT_BITS'(NUM_FRAMES)) begin
            idx      <= '0;
            free_n   <= '0;
            best_run <= '0;
            cur_run  <= '0;
            if (req_cmd == CMD_FREE) begin
              state <= S_FRAG;
              if (hit_all && resident_total != '0) begin
                resident_total <= resident_total - RESIDENT_BITS'(1);
              end
            end else if (hit_all) begin
              res_status <= ST_RESIDENT;
              state      <= S_FRAG;
            end else if (frames_per_process > lim) begin
              res_status <= ST_TOO_BIG;
              state      <= S_FRAG;
            end else if (!fit_found) begin
              res_status <= ST_NO_RUN;
              state      <= S_FRAG;
            end else begin
              res_status     <= ST_DONE;
              res_start      <= fit_start;
              wr_idx         <= fit_start;
              wr_cnt         <= frames_per_process;
              resident_total <= resident_total + RESIDENT_BITS'(1);
              state          <= S_WRITE;
            end
          end else begin
            idx <= idx + CNT_BITS'(1);
          end
        end

        // stamp the claimed run, one frame per cycle
        S_WRITE: begin
          busy[wr_idx] <= 1'b1;
          wr_idx       <= wr_idx + FRAME_BITS'(1);
          wr_cnt       <= wr_cnt - CFG_CNT_BITS'(1);
          if (wr_cnt == CFG_CNT_BITS'(1)) begin
            state <= S_FRAG;
          end
        end

        // free frames and largest free run over the managed region
        S_FRAG: begin
          if (in_region) begin
            if (idx_busy) begin
              cur_run <= '0;
            end else begin
              free_n  <= free_n + CNT_BITS'(1);
              cur_run <= cur_run_inc;
              if (cur_run_inc > best_run) begin
                best_run <= cur_run_inc;
              end
            end
          end
          idx <= idx + CNT_BITS'(1);
          if (idx == CNT_BITS'(NUM_FRAMES - 1)) begin
            state <= S_MUL;
          end
        end

        // scale by frame size
        S_MUL: begin
          frag_prod <= PROD_BITS'(frag_diff) * PROD_BITS'(frame_bytes);
          state     <= S_FINISH;
        end

        // hand the result word over once the output register is free
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}}, frag_sat,
                         resident_total, res_start, res_status};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // residents can never outnumber frames
  assert property (@(posedge clk) disable iff (rst)
    resident_total <= RESIDENT_BITS'(NUM_FRAMES))
    else $error("resident count above frame count");

  // a refused allocate reports start frame zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_BITS-1:0] != ST_DONE) |->
      (m_tdata[STATUS_BITS+START_BITS-1:STATUS_BITS] == '0))
    else $error("nonzero start frame on refused request");

  // a stamped frame is busy afterwards
  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> busy[$past(wr_idx)])
    else $error("written frame not marked busy");

  // owner writes only follow a successful allocate decision
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (req_cmd == CMD_ALLOC) && (res_status == ST_DONE) && !owner_hit)
    else $error("owner write outside a successful allocate");
`endif

endmodule

`default_nettype wire

// ===== test/first_fit_frame_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_frame_allocator_core_tb
// self-checking bench for the first-fit frame allocator core
// ----------------------------------------------------------------------------
// Requests go into the core from a queue that the stimulus process fills.
// Every accepted request updates a private copy of the frame table, which
// predicts the result word. The monitor checks each result word field by
// field against the oldest prediction. The run steps through several
// register settings, among them zero, oversize and full-size frame counts,
// a zero run length and the largest frame size. Of three regimes, the first
// two stall both stream sides at random and the last has no stalls at all.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_frame_allocator_core_tb
  import ffa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;  // unused index, ignored
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * NUM_FRAMES + 70;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic                 cmd;
    logic [ID_BITS-1:0]   pid;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic [START_BITS-1:0]    start;
    logic [RESIDENT_BITS-1:0] resident;
    logic [FRAG_BITS-1:0]     frag;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;    // [15:0] process_id
  logic [0:0]               s_tuser = '0;    // [0] cmd
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;         // [1:0] status, [7:2] start_frame,
                                             // [14:8] resident_count,
                                             // [36:15] fragment_bytes, [39:37] zero
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // predicted frame table and registers
  logic                  tbl_busy [NUM_FRAMES];
  logic [ID_BITS-1:0]    tbl_owner [NUM_FRAMES];
  int                    resident_total;
  logic [CFG_CNT_BITS-1:0] cfg_frames;
  logic [BYTES_BITS-1:0]   cfg_bytes;
  logic [CFG_CNT_BITS-1:0] cfg_run_len;

  request_t request_q [$];
  outcome_t outcome_q [$];
  logic [ID_BITS-1:0] id_pool [POOL_SIZE];

  int send_idle_pct = 11;
  int recv_idle_pct = 49;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  first_fit_frame_allocator_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: %s got %0d want %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // allocate or free against the predicted table, returns the result word
  function automatic outcome_t apply_request(input logic cmd, input logic [ID_BITS-1:0] pid);
    outcome_t o;
    int i;
    int lim;
    int run;
    int first;
    int found_at;
    int free_n;
    int best;
    bit owned;
    bit hit;
    longint bytes;
    o.status = ST_DONE;
    o.start = '0;
    lim = (int'(cfg_frames) > NUM_FRAMES) ? NUM_FRAMES : int'(cfg_frames);
    if (cmd == CMD_ALLOC) begin
      owned = 1'b0;
      for (i = 0; i < NUM_FRAMES; i++) begin
        if (tbl_busy[i] && tbl_owner[i] == pid) owned = 1'b1;
      end
      if (owned) begin
        o.status = ST_RESIDENT;
      end else if (int'(cfg_run_len) > lim) begin
        o.status = ST_TOO_BIG;
      end else begin
        // first fit over the managed region
        found_at = -1;
        run = 0;
        first = 0;
        if (cfg_run_len != 0) begin
          for (i = 0; i < lim && found_at < 0; i++) begin
            if (!tbl_busy[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == int'(cfg_run_len)) found_at = first;
            end else begin
              run = 0;
            end
          end
        end
        if (found_at < 0) begin
          o.status = ST_NO_RUN;
        end else begin
          for (i = found_at; i < found_at + int'(cfg_run_len) && i < NUM_FRAMES; i++) begin
            tbl_busy[i] = 1'b1;
            tbl_owner[i] = pid;
          end
          resident_total++;
          o.start = START_BITS'(found_at);
        end
      end
    end else begin
      // release everything the process holds, wherever it sits
      hit = 1'b0;
      for (i = 0; i < NUM_FRAMES; i++) begin
        if (tbl_busy[i] && tbl_owner[i] == pid) begin
          tbl_busy[i] = 1'b0;
          hit = 1'b1;
        end
      end
      if (hit && resident_total > 0) resident_total--;
    end
    o.resident = (resident_total > 127) ? 7'd127 : RESIDENT_BITS'(resident_total);
    // free frames outside the largest free run
    free_n = 0;
    best = 0;
    run = 0;
    for (i = 0; i < lim; i++) begin
      if (!tbl_busy[i]) begin
        free_n++;
        run++;
        if (run > best) best = run;
      end else begin
        run = 0;
      end
    end
    bytes = longint'(free_n - best) * longint'(cfg_bytes);
    o.frag = (bytes > longint'(FRAG_MAX)) ? FRAG_MAX : FRAG_BITS'(bytes);
    return o;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_requests
    bit go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(apply_request(s_tuser[0], s_tdata));
        void'(request_q.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        go = (request_q.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
        s_tvalid <= go;
        if (go) begin
          s_tdata <= request_q[0].pid;
          s_tuser <= request_q[0].cmd;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with none pending", longint'(m_tdata), 0);
        end else begin
          want = outcome_q.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", m_tdata[1:0], want.status);
          if (m_tdata[7:2] !== want.start)
            report_mismatch("start_frame", m_tdata[7:2], want.start);
          if (m_tdata[14:8] !== want.resident)
            report_mismatch("resident_count", m_tdata[14:8], want.resident);
          if (m_tdata[36:15] !== want.frag)
            report_mismatch("fragment_bytes", m_tdata[36:15], want.frag);
          if (m_tdata[OUT_DATA_BITS-1:37] !== '0)
            report_mismatch("pad bits", m_tdata[OUT_DATA_BITS-1:37], 0);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // stall watchdog
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("first_fit_frame_allocator_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAMES_IN_USE:      cfg_frames = val[CFG_CNT_BITS-1:0];
      REG_FRAME_BYTES:        cfg_bytes = val;
      REG_FRAMES_PER_PROCESS: cfg_run_len = val[CFG_CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic push_request(input logic cmd, input logic [ID_BITS-1:0] pid);
    request_t r;
    r.cmd = cmd;
    r.pid = pid;
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || outcome_q.size() != 0) @(negedge clk);
  endtask

  // count registers carry random upper bits, which the core drops
  task automatic run_phase(input int frames, input int bytes, input int run_len,
                           input int n, input int regime);
    int k;
    logic [ID_BITS-1:0] pid;
    wait_idle();
    write_reg(REG_FRAMES_IN_USE, {9'($urandom), 7'(frames)});
    write_reg(REG_FRAME_BYTES, 16'(bytes));
    write_reg(REG_FRAMES_PER_PROCESS, {9'($urandom), 7'(run_len)});
    @(negedge clk);
    case (regime)
      0: begin send_idle_pct = 11; recv_idle_pct = 49; end
      1: begin send_idle_pct = 49; recv_idle_pct = 11; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
    // mostly a small set of processes so runs fill, collide and free
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) pid = ID_BITS'($urandom);
      else pid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      push_request(($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE, pid);
      if (request_q.size() > 8) begin
        while (request_q.size() > 2) @(negedge clk);
      end
    end
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_FRAMES; i++) begin
      tbl_busy[i] = 1'b0;
      tbl_owner[i] = '0;
    end
    resident_total = 0;
    cfg_frames = RST_FRAMES_IN_USE;
    cfg_bytes = RST_FRAME_BYTES;
    cfg_run_len = RST_FRAMES_PER_PROCESS;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_BITS'($urandom);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, holes, first fit into a hole, full table
    @(negedge clk);
    push_request(CMD_FREE, 16'h0000);
    push_request(CMD_ALLOC, 16'h0000);
    push_request(CMD_ALLOC, 16'h0000);
    push_request(CMD_ALLOC, 16'hFFFF);
    push_request(CMD_ALLOC, 16'h5555);
    push_request(CMD_ALLOC, 16'hAAAA);
    push_request(CMD_FREE, 16'hFFFF);
    push_request(CMD_ALLOC, 16'h1234);
    push_request(CMD_FREE, 16'h5555);
    for (i = 1; i <= 14; i++) push_request(CMD_ALLOC, 16'(i));
    push_request(CMD_FREE, 16'hAAAA);
    push_request(CMD_FREE, 16'h0007);
    push_request(CMD_ALLOC, 16'h8001);
    wait_idle();
    write_reg(REG_SPARE, 16'($urandom));

    run_phase(64, 16, 4, 180, 0);
    run_phase(64, 65535, 1, 200, 0);
    run_phase(7, 1, 3, 120, 0);
    run_phase(0, 300, 2, 60, 1);
    run_phase(100, 2, 64, 120, 1);
    run_phase(127, 9, 0, 60, 1);
    run_phase(64, 1000, 127, 60, 2);
    run_phase(1, 65535, 1, 100, 2);
    run_phase(33, $urandom_range(1, 65535), 5, 250, 2);
    run_phase(64, $urandom_range(1, 65535), 3, 250, 2);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("first_fit_frame_allocator_core: match");
    end else begin
      $display("first_fit_frame_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
